[rtl/rmsn_pkg.sv]
// Shared constants, state codes and rounding helper for the RMS norm block.
`default_nettype none
package rmsn_pkg;

    localparam int LANES     = 4;
    localparam int LANE_W    = $clog2(LANES);
    localparam int X_W       = 16;
    localparam int CFG_W     = 24;
    localparam int GPR_W     = 7;
    localparam int EPS_W     = 24;
    localparam int SCALE_W   = 24;
    localparam int NUM_W     = 64;
    localparam int DEN_W     = 32;
    localparam int MUL_A_W   = 41;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SQ_W      = 31;
    localparam int ROOT_W    = NUM_W / 2;
    localparam int ROOT_IT_W = $clog2(ROOT_W);
    localparam int REM_W     = ROOT_W + 2;
    localparam int INV_SHIFT = 56;
    localparam int RND_SHIFT = 28;

    localparam logic [0:0] REG_GROUPS  = 1'b0;
    localparam logic [0:0] REG_EPSILON = 1'b1;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_SQUARE    = 10'b00_0000_0010,
        ST_MEAN_GO   = 10'b00_0000_0100,
        ST_MEAN_WAIT = 10'b00_0000_1000,
        ST_INV_WAIT  = 10'b00_0001_0000,
        ST_SQRT      = 10'b00_0010_0000,
        ST_READ      = 10'b00_0100_0000,
        ST_MUL1      = 10'b00_1000_0000,
        ST_MUL2      = 10'b01_0000_0000,
        ST_ROUND     = 10'b10_0000_0000
    } state_t;

    function automatic logic [X_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
        logic              neg;
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] biased;
        logic [PROD_W-RND_SHIFT-1:0] q;
        logic [X_W-1:0]    y;
        neg    = p[PROD_W-1];
        mag    = neg ? (~p + PROD_W'(1)) : p;
        biased = mag + (PROD_W'(1) << (RND_SHIFT - 1));
        q      = biased[PROD_W-1:RND_SHIFT];
        if (neg)
        begin
            y = (q > (PROD_W-RND_SHIFT)'(32768)) ? 16'h8000 : (~q[X_W-1:0] + 16'd1);
        end
        else
        begin
            y = (q > (PROD_W-RND_SHIFT)'(32767)) ? 16'h7FFF : q[X_W-1:0];
        end
        return y;
    endfunction

endpackage
`default_nettype wire

[rtl/rms_norm_weight_multiply.sv]
// RMS normalization with weight multiply: row store, shared multiplier, sequencer.
//
//  channel   | signals                                   | transfer
//  ----------+-------------------------------------------+------------------------------
//  input     | start, busy, x_lane0..3, weight_lane0..3  | start high while busy low
//  result    | result_valid, y_lane0..3, row_end,        | every cycle result_valid high
//            | zero_energy                               |
//  config    | cfg_write, cfg_index, cfg_data            | every cycle cfg_write high
//
// A group is accepted, then each lane is squared in turn through the shared multiplier.
// After the last group of a row: mean divide, then inverse divide and square root unless
// mean plus epsilon is zero, then each stored group replayed through the multiplier.
// Reset clears sequencer, sum, count and flags, presets config; row store needs no clearing.
// Results are shown for one cycle each and cannot be held off.
`default_nettype none
module rms_norm_weight_multiply #(
    parameter int MAX_GROUPS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic signed [15:0] x_lane0,
    input  wire logic signed [15:0] x_lane1,
    input  wire logic signed [15:0] x_lane2,
    input  wire logic signed [15:0] x_lane3,
    input  wire logic signed [15:0] weight_lane0,
    input  wire logic signed [15:0] weight_lane1,
    input  wire logic signed [15:0] weight_lane2,
    input  wire logic signed [15:0] weight_lane3,
    output logic             result_valid,
    output logic signed [15:0] y_lane0,
    output logic signed [15:0] y_lane1,
    output logic signed [15:0] y_lane2,
    output logic signed [15:0] y_lane3,
    output logic             row_end,
    output logic             zero_energy,
    input  wire logic        cfg_write,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [rmsn_pkg::CFG_W-1:0] cfg_data
);

    localparam int AW     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CW     = $clog2(MAX_GROUPS + 1);
    localparam int SUM_W  = rmsn_pkg::SQ_W + $clog2(MAX_GROUPS * rmsn_pkg::LANES) + 1;
    localparam int LEN_W  = 16;
    localparam int WORD_W = 2 * rmsn_pkg::LANES * rmsn_pkg::X_W;
    localparam int HALF_W = rmsn_pkg::LANES * rmsn_pkg::X_W;
    localparam int LAST_LANE = rmsn_pkg::LANES - 1;

    rmsn_pkg::state_t state_reg, state_next;

    logic [rmsn_pkg::GPR_W-1:0]   gpr_reg;
    logic [rmsn_pkg::EPS_W-1:0]   eps_reg;
    logic [SUM_W-1:0]             sum_reg, sum_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                k_reg, k_next;
    logic [rmsn_pkg::LANE_W-1:0]  lane_reg, lane_next;
    logic [HALF_W-1:0]            xin_reg, xin_next;
    logic                         zero_reg, zero_next;
    logic [rmsn_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic [rmsn_pkg::NUM_W-1:0]   rad_reg, rad_next;
    logic [rmsn_pkg::ROOT_W-1:0]  root_reg, root_next;
    logic [rmsn_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [rmsn_pkg::ROOT_IT_W-1:0] it_reg, it_next;
    logic signed [rmsn_pkg::MUL_A_W-1:0] p1_reg, p1_next;
    logic signed [rmsn_pkg::PROD_W-1:0]  p2_reg, p2_next;
    logic [rmsn_pkg::X_W-1:0]     y_reg [rmsn_pkg::LANES];
    logic [rmsn_pkg::X_W-1:0]     y_next [rmsn_pkg::LANES];
    logic                         emit_reg, emit_next;
    logic                         last_reg, last_next;

    logic [WORD_W-1:0]            row_mem [MAX_GROUPS];
    logic [WORD_W-1:0]            rd_reg;
    logic                         mem_we;

    logic                         div_start;
    logic [rmsn_pkg::NUM_W-1:0]   div_num;
    logic [rmsn_pkg::DEN_W-1:0]   div_den;
    logic                         div_done;
    logic [rmsn_pkg::NUM_W-1:0]   div_quot;

    logic signed [rmsn_pkg::MUL_A_W-1:0] mul_a;
    logic signed [rmsn_pkg::MUL_B_W-1:0] mul_b;
    logic signed [rmsn_pkg::PROD_W-1:0]  prod;

    logic [LEN_W-1:0]             len;
    logic [CW-1:0]                count_inc;
    logic [rmsn_pkg::DEN_W-1:0]   total;
    logic [rmsn_pkg::REM_W-1:0]   rem_sh;
    logic [rmsn_pkg::REM_W-1:0]   trial;
    logic signed [rmsn_pkg::X_W-1:0] x_cur;
    logic signed [rmsn_pkg::X_W-1:0] x_sq;
    logic signed [rmsn_pkg::X_W-1:0] w_cur;
    logic [HALF_W-1:0]            in_x;
    logic [HALF_W-1:0]            in_w;

    assign in_x = {x_lane3, x_lane2, x_lane1, x_lane0};
    assign in_w = {weight_lane3, weight_lane2, weight_lane1, weight_lane0};

    rmsn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign x_sq  = xin_reg[lane_reg * rmsn_pkg::X_W +: rmsn_pkg::X_W];
    assign x_cur = rd_reg[lane_reg * rmsn_pkg::X_W +: rmsn_pkg::X_W];
    assign w_cur = rd_reg[HALF_W + lane_reg * rmsn_pkg::X_W +: rmsn_pkg::X_W];

    always_comb
    begin
        unique case (state_reg)
            rmsn_pkg::ST_MUL1:
            begin
                mul_a = $signed({{(rmsn_pkg::MUL_A_W - rmsn_pkg::SCALE_W){1'b0}}, scale_reg});
                mul_b = rmsn_pkg::MUL_B_W'(x_cur);
            end
            rmsn_pkg::ST_MUL2:
            begin
                mul_a = p1_reg;
                mul_b = rmsn_pkg::MUL_B_W'(w_cur);
            end
            default:
            begin
                mul_a = rmsn_pkg::MUL_A_W'(x_sq);
                mul_b = rmsn_pkg::MUL_B_W'(x_sq);
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_comb
    begin
        if (gpr_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (LEN_W'(gpr_reg) > LEN_W'(MAX_GROUPS))
        begin
            len = LEN_W'(MAX_GROUPS);
        end
        else
        begin
            len = LEN_W'(gpr_reg);
        end
    end

    assign count_inc = count_reg + CW'(1);
    assign total     = div_quot[rmsn_pkg::DEN_W-1:0] + rmsn_pkg::DEN_W'(eps_reg);
    assign rem_sh    = {rem_reg[rmsn_pkg::REM_W-3:0], rad_reg[rmsn_pkg::NUM_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        k_next     = k_reg;
        lane_next  = lane_reg;
        xin_next   = xin_reg;
        zero_next  = zero_reg;
        scale_next = scale_reg;
        rad_next   = rad_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        it_next    = it_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        y_next     = y_reg;
        emit_next  = 1'b0;
        last_next  = last_reg;
        mem_we     = 1'b0;
        div_start  = 1'b0;
        div_num    = rmsn_pkg::NUM_W'(sum_reg);
        div_den    = rmsn_pkg::DEN_W'(count_reg) * rmsn_pkg::DEN_W'(rmsn_pkg::LANES);
        unique case (state_reg)
            rmsn_pkg::ST_IDLE:
            begin
                if (start && !busy)
                begin
                    mem_we     = 1'b1;
                    xin_next   = in_x;
                    lane_next  = '0;
                    state_next = rmsn_pkg::ST_SQUARE;
                end
            end
            rmsn_pkg::ST_SQUARE:
            begin
                sum_next  = sum_reg + SUM_W'(prod[rmsn_pkg::SQ_W-1:0]);
                lane_next = lane_reg + rmsn_pkg::LANE_W'(1);
                if (lane_reg == rmsn_pkg::LANE_W'(LAST_LANE))
                begin
                    count_next = count_inc;
                    state_next = (LEN_W'(count_inc) >= len) ? rmsn_pkg::ST_MEAN_GO
                                                              : rmsn_pkg::ST_IDLE;
                end
            end
            rmsn_pkg::ST_MEAN_GO:
            begin
                div_start  = 1'b1;
                state_next = rmsn_pkg::ST_MEAN_WAIT;
            end
            rmsn_pkg::ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    if (total == '0)
                    begin
                        zero_next  = 1'b1;
                        scale_next = '0;
                        k_next     = '0;
                        state_next = rmsn_pkg::ST_READ;
                    end
                    else
                    begin
                        zero_next  = 1'b0;
                        div_start  = 1'b1;
                        div_num    = rmsn_pkg::NUM_W'(1) << rmsn_pkg::INV_SHIFT;
                        div_den    = total;
                        state_next = rmsn_pkg::ST_INV_WAIT;
                    end
                end
            end
            rmsn_pkg::ST_INV_WAIT:
            begin
                if (div_done)
                begin
                    rad_next   = div_quot;
                    root_next  = '0;
                    rem_next   = '0;
                    it_next    = '0;
                    state_next = rmsn_pkg::ST_SQRT;
                end
            end
            rmsn_pkg::ST_SQRT:
            begin
                rad_next = {rad_reg[rmsn_pkg::NUM_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[rmsn_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[rmsn_pkg::ROOT_W-2:0], 1'b0};
                end
                it_next = it_reg + rmsn_pkg::ROOT_IT_W'(1);
                if (it_reg == rmsn_pkg::ROOT_IT_W'(rmsn_pkg::ROOT_W - 1))
                begin
                    scale_next = (root_next > rmsn_pkg::ROOT_W'({rmsn_pkg::SCALE_W{1'b1}}))
                               ? {rmsn_pkg::SCALE_W{1'b1}}
                               : root_next[rmsn_pkg::SCALE_W-1:0];
                    k_next     = '0;
                    state_next = rmsn_pkg::ST_READ;
                end
            end
            rmsn_pkg::ST_READ:
            begin
                lane_next  = '0;
                last_next  = (k_reg + CW'(1)) == count_reg;
                state_next = rmsn_pkg::ST_MUL1;
            end
            rmsn_pkg::ST_MUL1:
            begin
                p1_next    = prod[rmsn_pkg::MUL_A_W-1:0];
                state_next = rmsn_pkg::ST_MUL2;
            end
            rmsn_pkg::ST_MUL2:
            begin
                p2_next    = prod;
                state_next = rmsn_pkg::ST_ROUND;
            end
            rmsn_pkg::ST_ROUND:
            begin
                y_next[lane_reg] = rmsn_pkg::round_sat(p2_reg);
                lane_next        = lane_reg + rmsn_pkg::LANE_W'(1);
                if (lane_reg == rmsn_pkg::LANE_W'(LAST_LANE))
                begin
                    emit_next = 1'b1;
                    k_next    = k_reg + CW'(1);
                    if (last_reg)
                    begin
                        sum_next   = '0;
                        count_next = '0;
                        state_next = rmsn_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = rmsn_pkg::ST_READ;
                    end
                end
                else
                begin
                    state_next = rmsn_pkg::ST_MUL1;
                end
            end
            default:
            begin
                state_next = rmsn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmsn_pkg::ST_IDLE;
            gpr_reg   <= rmsn_pkg::GPR_W'(64);
            eps_reg   <= rmsn_pkg::EPS_W'(1);
            sum_reg   <= '0;
            count_reg <= '0;
            k_reg     <= '0;
            lane_reg  <= '0;
            it_reg    <= '0;
            zero_reg  <= 1'b0;
            emit_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            lane_reg  <= lane_next;
            it_reg    <= it_next;
            zero_reg  <= zero_next;
            emit_reg  <= emit_next;
            last_reg  <= last_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    rmsn_pkg::REG_GROUPS:  gpr_reg <= cfg_data[rmsn_pkg::GPR_W-1:0];
                    rmsn_pkg::REG_EPSILON: eps_reg <= cfg_data[rmsn_pkg::EPS_W-1:0];
                    default:               gpr_reg <= gpr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        xin_reg   <= xin_next;
        scale_reg <= scale_next;
        rad_reg   <= rad_next;
        root_reg  <= root_next;
        rem_reg   <= rem_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        y_reg     <= y_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[count_reg[AW-1:0]] <= {in_w, in_x};
        end
        rd_reg <= row_mem[k_reg[AW-1:0]];
    end

    assign busy         = state_reg != rmsn_pkg::ST_IDLE || emit_reg;
    assign result_valid = emit_reg;
    assign y_lane0      = y_reg[0];
    assign y_lane1      = y_reg[1];
    assign y_lane2      = y_reg[2];
    assign y_lane3      = y_reg[3];
    assign row_end      = last_reg;
    assign zero_energy  = zero_reg;

endmodule
`default_nettype wire

[rtl/rmsn_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rmsn_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [rmsn_pkg::NUM_W-1:0] num,
    input  wire logic [rmsn_pkg::DEN_W-1:0] den,
    output logic                           done,
    output logic [rmsn_pkg::NUM_W-1:0]     quot
);

    localparam int CNT_W = $clog2(rmsn_pkg::NUM_W);

    logic                        active_reg, active_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [rmsn_pkg::DEN_W:0]    rem_reg, rem_next;
    logic [rmsn_pkg::NUM_W-1:0]  quo_reg, quo_next;
    logic [rmsn_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [rmsn_pkg::DEN_W:0]    shifted;
    logic                        fits;

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        den_next    = den_reg;
        shifted     = {rem_reg[rmsn_pkg::DEN_W-1:0], quo_reg[rmsn_pkg::NUM_W-1]};
        fits        = shifted >= {1'b0, den_reg};
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            rem_next    = '0;
            quo_next    = num;
            den_next    = den;
        end
        else if (active_reg)
        begin
            rem_next = fits ? (shifted - {1'b0, den_reg}) : shifted;
            quo_next = {quo_reg[rmsn_pkg::NUM_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(rmsn_pkg::NUM_W - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule
`default_nettype wire

[rtl/rmsn_check.sv]
// Port-level checker for the RMS norm block, bound to the top level.
`default_nettype none
module rmsn_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        result_valid,
    input wire logic [15:0] y_lane0,
    input wire logic [15:0] y_lane1,
    input wire logic [15:0] y_lane2,
    input wire logic [15:0] y_lane3,
    input wire logic        row_end,
    input wire logic        zero_energy
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transfer did not raise busy");

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result while idle");

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && zero_energy |->
            y_lane0 == 16'd0 && y_lane1 == 16'd0 && y_lane2 == 16'd0 && y_lane3 == 16'd0)
        else $error("zero energy result carries nonzero data");

    a_row_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && row_end |=> !result_valid)
        else $error("result right after row end");

endmodule

bind rms_norm_weight_multiply rmsn_check u_rmsn_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .y_lane0      (y_lane0),
    .y_lane1      (y_lane1),
    .y_lane2      (y_lane2),
    .y_lane3      (y_lane3),
    .row_end      (row_end),
    .zero_energy  (zero_energy)
);
`default_nettype wire
